// ===== hdl/line_ending_converter_macros.svh =====
// ----------------------------------------------------------------------------
// Line ending converter assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_ENDING_CONVERTER_MACROS_SVH
`define LINE_ENDING_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define LEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line ending converter package
// Codes, payload types and job record shared by the converter modules.
// ----------------------------------------------------------------------------
package lec_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int REPORT_W        = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 2;
    localparam int MAX_CODES       = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_NT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FOREIGN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_FINAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN       = 3'd4;

    // terminator conventions
    localparam logic [1:0] CONV_NONE = 2'd0;
    localparam logic [1:0] CONV_CR   = 2'd1;
    localparam logic [1:0] CONV_LF   = 2'd2;
    localparam logic [1:0] CONV_CRLF = 2'd3;

    // byte layouts
    localparam logic [1:0] LAYOUT_8  = 2'd0;
    localparam logic [1:0] LAYOUT_LE = 2'd1;
    localparam logic [1:0] LAYOUT_BE = 2'd2;

    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_END    = 1'b1;
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [7:0]  BOM_FF = 8'hFF;
    localparam logic [7:0]  BOM_FE = 8'hFE;
    localparam logic [15:0] CH_CR  = 16'd13;
    localparam logic [15:0] CH_LF  = 16'd10;
    localparam logic [15:0] CTRL_LOW_MAX  = 16'd8;
    localparam logic [15:0] CTRL_HIGH_MIN = 16'd14;
    localparam logic [15:0] CTRL_HIGH_MAX = 16'd31;

    typedef struct packed {
        logic [1:0] target_convention;
        logic       stop_on_non_text;
        logic       stop_on_foreign_ending;
        logic       force_final_ending;
        logic       output_enable;
    } t_cfg;

    typedef struct packed {
        logic       func;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic                kind;
        logic [7:0]          out_byte;
        logic [REPORT_W-1:0] cr_total;
        logic [REPORT_W-1:0] lf_total;
        logic [REPORT_W-1:0] crlf_total;
        logic                saw_non_text;
        logic                was_stopped;
        logic                last;
    } t_out;

    // One accepted item's work for the back end: code points, then an
    // optional report.
    typedef struct packed {
        logic                           report;
        logic [1:0]                     layout;
        logic [2:0]                     n_codes;
        logic [MAX_CODES-1:0][15:0]     codes;
        logic [REPORT_W-1:0]            cr_total;
        logic [REPORT_W-1:0]            lf_total;
        logic [REPORT_W-1:0]            crlf_total;
        logic                           saw_non_text;
        logic                           was_stopped;
    } t_job;

endpackage

// ===== hdl/lec_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface lec_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/lec_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter front end
// Holds configuration, detects layout, assembles code points, classifies
// terminators and counts them; pushes one job per productive transfer.
// ----------------------------------------------------------------------------
module lec_front #(
    parameter int COUNT_WIDTH = lec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lec_stream_if.sink                     i_in,
    input  logic                           i_cfg_we,
    input  logic [lec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_q_full,
    output logic                           o_push,
    output lec_pkg::t_job                  o_job
);

    typedef struct packed {
        logic                   prev_cr;
        logic                   prev_nl;
        logic                   halted;
        logic                   non_text;
        logic [COUNT_WIDTH-1:0] cr;
        logic [COUNT_WIDTH-1:0] lf;
        logic [COUNT_WIDTH-1:0] crlf;
    } t_stat;

    typedef struct packed {
        t_stat                                st;
        logic [2:0]                           n;
        logic [lec_pkg::MAX_CODES-1:0][15:0]  codes;
    } t_ctx;

    function automatic logic [COUNT_WIDTH-1:0] f_inc(logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_ctx f_put(t_ctx c, logic [15:0] w, lec_pkg::t_cfg cfg);
        t_ctx r;
        r = c;
        if (cfg.output_enable && (r.n < 3'(lec_pkg::MAX_CODES))) begin
            r.codes[r.n[1:0]] = w;
            r.n               = 3'(r.n + 3'd1);
        end
        return r;
    endfunction

    function automatic t_ctx f_newline(t_ctx c, lec_pkg::t_cfg cfg);
        t_ctx r;
        r = c;
        case (cfg.target_convention)
            lec_pkg::CONV_CR:   r = f_put(r, lec_pkg::CH_CR, cfg);
            lec_pkg::CONV_LF:   r = f_put(r, lec_pkg::CH_LF, cfg);
            lec_pkg::CONV_CRLF: begin
                r = f_put(r, lec_pkg::CH_CR, cfg);
                r = f_put(r, lec_pkg::CH_LF, cfg);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_ctx f_code(t_ctx c, logic [15:0] w, lec_pkg::t_cfg cfg);
        t_ctx r;
        r = c;
        if (!r.st.halted) begin
            if ((w <= lec_pkg::CTRL_LOW_MAX) ||
                ((w >= lec_pkg::CTRL_HIGH_MIN) && (w <= lec_pkg::CTRL_HIGH_MAX))) begin
                r.st.prev_nl  = 1'b0;
                r.st.non_text = 1'b1;
                if (cfg.stop_on_non_text) begin
                    r.st.halted = 1'b1;
                end
            end
            if (!r.st.halted) begin
                if (w == lec_pkg::CH_CR) begin
                    if (r.st.prev_cr) begin
                        r.st.cr = f_inc(r.st.cr);
                    end
                    r          = f_newline(r, cfg);
                    r.st.prev_cr = 1'b1;
                    r.st.prev_nl = 1'b1;
                end else if (w == lec_pkg::CH_LF) begin
                    r.st.prev_nl = 1'b1;
                    if (r.st.prev_cr) begin
                        r.st.prev_cr = 1'b0;
                        r.st.crlf    = f_inc(r.st.crlf);
                        if (cfg.stop_on_foreign_ending &&
                            (cfg.target_convention != lec_pkg::CONV_CRLF)) begin
                            r.st.halted = 1'b1;
                        end
                    end else begin
                        r       = f_newline(r, cfg);
                        r.st.lf = f_inc(r.st.lf);
                        if (cfg.stop_on_foreign_ending &&
                            (cfg.target_convention != lec_pkg::CONV_LF)) begin
                            r.st.halted = 1'b1;
                        end
                    end
                end else begin
                    if (r.st.prev_cr) begin
                        r.st.cr = f_inc(r.st.cr);
                    end
                    r            = f_put(r, w, cfg);
                    r.st.prev_cr = 1'b0;
                    r.st.prev_nl = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] f_join(logic [1:0] lay, logic [7:0] a, logic [7:0] b);
        return (lay == lec_pkg::LAYOUT_LE) ? {b, a} : {a, b};
    endfunction

    lec_pkg::t_cfg r_cfg;
    t_stat         r_st,     n_st;
    logic [1:0]    r_seen,   n_seen;
    logic [7:0]    r_first,  n_first;
    logic [1:0]    r_layout, n_layout;
    logic [7:0]    r_half,   n_half;
    logic          r_half_pend, n_half_pend;

    t_ctx          c;
    logic          rep;
    logic          accept;
    logic [1:0]    det_layout;
    logic [1:0]    job_layout;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        c            = '0;
        c.st         = r_st;
        rep          = 1'b0;
        n_seen       = r_seen;
        n_first      = r_first;
        n_layout     = r_layout;
        n_half       = r_half;
        n_half_pend  = r_half_pend;
        det_layout   = lec_pkg::LAYOUT_8;
        job_layout   = r_layout;
        if ((r_first == lec_pkg::BOM_FF) && (i_in.data.in_byte == lec_pkg::BOM_FE)) begin
            det_layout = lec_pkg::LAYOUT_LE;
        end else if ((r_first == lec_pkg::BOM_FE) &&
                     (i_in.data.in_byte == lec_pkg::BOM_FF)) begin
            det_layout = lec_pkg::LAYOUT_BE;
        end

        if (i_in.data.func == lec_pkg::FUNC_DATA) begin
            case (r_seen)
                2'd0: begin
                    n_first = i_in.data.in_byte;
                    n_seen  = 2'd1;
                end
                2'd1: begin
                    n_seen     = 2'd2;
                    n_layout   = det_layout;
                    job_layout = det_layout;
                    if (det_layout == lec_pkg::LAYOUT_8) begin
                        c = f_code(c, {8'h00, r_first}, r_cfg);
                        c = f_code(c, {8'h00, i_in.data.in_byte}, r_cfg);
                    end else begin
                        c = f_code(c, f_join(det_layout, r_first, i_in.data.in_byte), r_cfg);
                    end
                end
                default: begin
                    if ((r_layout == lec_pkg::LAYOUT_LE) || (r_layout == lec_pkg::LAYOUT_BE)) begin
                        if (r_half_pend) begin
                            n_half_pend = 1'b0;
                            c = f_code(c, f_join(r_layout, r_half, i_in.data.in_byte), r_cfg);
                        end else begin
                            n_half      = i_in.data.in_byte;
                            n_half_pend = 1'b1;
                        end
                    end else begin
                        c = f_code(c, {8'h00, i_in.data.in_byte}, r_cfg);
                    end
                end
            endcase
            n_st = c.st;
        end else begin
            // end of stream: flush the held byte and a trailing CR
            if (r_seen == 2'd1) begin
                c = f_code(c, {8'h00, r_first}, r_cfg);
            end
            if (c.st.prev_cr) begin
                c.st.cr      = f_inc(c.st.cr);
                c.st.prev_cr = 1'b0;
            end
            if (r_cfg.force_final_ending && !c.st.prev_nl) begin
                c = f_newline(c, r_cfg);
            end
            rep         = 1'b1;
            n_st        = '0;
            n_seen      = 2'd0;
            n_first     = 8'h00;
            n_layout    = lec_pkg::LAYOUT_8;
            n_half      = 8'h00;
            n_half_pend = 1'b0;
        end

        o_job.report       = rep;
        o_job.layout       = job_layout;
        o_job.n_codes      = c.n;
        o_job.codes        = c.codes;
        o_job.cr_total     = lec_pkg::REPORT_W'(c.st.cr);
        o_job.lf_total     = lec_pkg::REPORT_W'(c.st.lf);
        o_job.crlf_total   = lec_pkg::REPORT_W'(c.st.crlf);
        o_job.saw_non_text = c.st.non_text;
        o_job.was_stopped  = c.st.halted;
    end

    assign o_push = accept && (rep || (c.n != 3'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_convention      <= lec_pkg::CONV_LF;
            r_cfg.stop_on_non_text       <= 1'b0;
            r_cfg.stop_on_foreign_ending <= 1'b0;
            r_cfg.force_final_ending     <= 1'b0;
            r_cfg.output_enable          <= 1'b1;
            r_st        <= '0;
            r_seen      <= 2'd0;
            r_first     <= 8'h00;
            r_layout    <= lec_pkg::LAYOUT_8;
            r_half      <= 8'h00;
            r_half_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lec_pkg::CFG_TARGET:       r_cfg.target_convention      <= i_cfg_data;
                    lec_pkg::CFG_STOP_NT:      r_cfg.stop_on_non_text       <= i_cfg_data[0];
                    lec_pkg::CFG_STOP_FOREIGN: r_cfg.stop_on_foreign_ending <= i_cfg_data[0];
                    lec_pkg::CFG_FORCE_FINAL:  r_cfg.force_final_ending     <= i_cfg_data[0];
                    lec_pkg::CFG_OUT_EN:       r_cfg.output_enable          <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_st        <= n_st;
                r_seen      <= n_seen;
                r_first     <= n_first;
                r_layout    <= n_layout;
                r_half      <= n_half;
                r_half_pend <= n_half_pend;
            end
        end
    end

endmodule

// ===== hdl/lec_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module lec_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lec_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output lec_pkg::t_job o_head,
    output logic          o_head_valid
);

    lec_pkg::t_job r_slot [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= 2'(r_cnt + {1'b0, i_push} - {1'b0, i_pop});
        end
    end

endmodule

// ===== hdl/lec_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter back end
// Expands the head job into output bytes in its layout, then the report,
// one result per transfer through an output register.
// ----------------------------------------------------------------------------
`include "line_ending_converter_macros.svh"

module lec_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lec_pkg::t_job i_head,
    input  logic          i_head_valid,
    output logic          o_pop,
    lec_stream_if.source  o_out
);

    logic          r_valid;
    lec_pkg::t_out r_data, n_data;
    logic [2:0]    r_idx;
    logic          r_half;

    logic          in_codes;
    logic          wide;
    logic          code_end;
    logic          done;
    logic          load;
    logic [15:0]   cur_code;
    logic [7:0]    cur_byte;

    assign in_codes = (r_idx < i_head.n_codes);
    assign wide     = (i_head.layout == lec_pkg::LAYOUT_LE) ||
                      (i_head.layout == lec_pkg::LAYOUT_BE);
    assign code_end = !wide || r_half;
    assign cur_code = i_head.codes[r_idx[1:0]];
    assign done     = in_codes ? (code_end && (3'(r_idx + 3'd1) == i_head.n_codes) &&
                                  !i_head.report)
                               : 1'b1;
    assign load     = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop    = load && done;

    always_comb begin
        // big-endian sends the high byte first
        if ((i_head.layout == lec_pkg::LAYOUT_BE) ^ r_half) begin
            cur_byte = cur_code[15:8];
        end else begin
            cur_byte = cur_code[7:0];
        end
        n_data = '0;
        if (in_codes) begin
            n_data.kind     = lec_pkg::KIND_BYTE;
            n_data.out_byte = cur_byte;
        end else begin
            n_data.kind         = lec_pkg::KIND_REPORT;
            n_data.cr_total     = i_head.cr_total;
            n_data.lf_total     = i_head.lf_total;
            n_data.crlf_total   = i_head.crlf_total;
            n_data.saw_non_text = i_head.saw_non_text;
            n_data.was_stopped  = i_head.was_stopped;
        end
        n_data.last = done;
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                if (done) begin
                    r_idx  <= 3'd0;
                    r_half <= 1'b0;
                end else if (code_end) begin
                    r_idx  <= 3'(r_idx + 3'd1);
                    r_half <= 1'b0;
                end else begin
                    r_half <= 1'b1;
                end
            end
        end
    end

    `LEC_ASSERT_NOW(a_report_is_last, i_clk, i_rst_n, r_valid && (r_data.kind == lec_pkg::KIND_REPORT), r_data.last, "report result not marked last")
    `LEC_ASSERT_NOW(a_idx_bound, i_clk, i_rst_n, i_head_valid, in_codes || ((r_idx == i_head.n_codes) && i_head.report), "code index past end of job")
    `LEC_ASSERT_NEXT(a_job_held, i_clk, i_rst_n, load && !done, i_head_valid, "job left queue before last result")
    `LEC_ASSERT_NOW(a_byte_no_counts, i_clk, i_rst_n, r_valid && (r_data.kind == lec_pkg::KIND_BYTE), (r_data.cr_total == '0) && (r_data.lf_total == '0) && (r_data.crlf_total == '0) && !r_data.was_stopped, "byte result carries report fields")

endmodule

// ===== hdl/line_ending_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line ending converter
// Byte-stream newline converter with layout detection, terminator counts
// and an end-of-stream report.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                           Handshake
// i_in      in   func, in_byte                                     valid/ready
// o_out     out  kind, out_byte, cr/lf/crlf_total, flags, last     valid/ready
// i_cfg_*   in   register index, data                              write enable
//
// One input byte is taken per cycle while the job queue has room; the front
// end does all classification in that cycle.
// The back end sends one result per transfer, so an item that gives k
// results holds the back end until all k have left (k is at most 5).
// The two-entry job queue lets input flow on while a result waits at o_out.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module line_ending_converter #(
    parameter int COUNT_WIDTH = lec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lec_stream_if.sink                     i_in,
    lec_stream_if.source                   o_out,
    input  logic                           i_cfg_we,
    input  logic [lec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lec_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // front end to queue
    logic          push;
    logic          q_full;
    lec_pkg::t_job front_job;

    // queue to back end
    logic          pop;
    logic          head_valid;
    lec_pkg::t_job head_job;

    // Detect layout, assemble code points, count and classify terminators.
    lec_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (front_job)
    );

    // Hold jobs so each side can stall on its own.
    lec_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (front_job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head       (head_job),
        .o_head_valid (head_valid)
    );

    // Expand code points into bytes and deliver the report.
    lec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line ending converter testbench
// Drives byte streams through the converter under a series of register
// settings and stall patterns, predicts every converted byte and end-of-
// stream report in step with each accepted transfer, and compares the
// results field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb_top;

    import lec_pkg::*;

    localparam int MAX_RESULTS     = 5;        // results one transfer can cause
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 28;       // counted random transfers per phase
    localparam int SETTLE_CYCLES   = 16;       // quiet cycles before a register write
    localparam int LONG_HOLD       = 80;       // receiver hold-off, in cycles
    localparam int MAX_REPORTED    = 10;
    localparam int TIMEOUT_NS      = 5_000_000;

    // Mirror of the converter: register copy, stream state and the queue of
    // results still owed by the block.
    class ending_checker;
        t_cfg        cfg;
        logic [1:0]  bytes_seen;
        logic [7:0]  first_byte;
        logic [1:0]  layout;
        logic [7:0]  half_byte;
        bit          half_pending;
        bit          prev_cr;
        bit          prev_newline;
        bit          halted;
        bit          non_text;
        logic [31:0] cr_cnt;
        logic [31:0] lf_cnt;
        logic [31:0] crlf_cnt;
        t_out        batch[$];
        t_out        due_results[$];
        int          n_errors;

        function new();
            cfg = '{CONV_LF, 1'b0, 1'b0, 1'b0, 1'b1};
            n_errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            bytes_seen   = '0;
            first_byte   = '0;
            layout       = LAYOUT_8;
            half_byte    = '0;
            half_pending = 1'b0;
            prev_cr      = 1'b0;
            prev_newline = 1'b0;
            halted       = 1'b0;
            non_text     = 1'b0;
            cr_cnt       = '0;
            lf_cnt       = '0;
            crlf_cnt     = '0;
        endfunction

        function logic [31:0] bump(logic [31:0] c);
            return (c == '1) ? c : c + 32'd1;
        endfunction

        function void emit_byte(logic [7:0] b);
            t_out r;
            if (batch.size() >= MAX_RESULTS) return;
            r          = '0;
            r.kind     = KIND_BYTE;
            r.out_byte = b;
            batch.push_back(r);
        endfunction

        function void put_code(logic [15:0] w);
            if (!cfg.output_enable) return;
            case (layout)
                LAYOUT_LE: begin
                    emit_byte(w[7:0]);
                    emit_byte(w[15:8]);
                end
                LAYOUT_BE: begin
                    emit_byte(w[15:8]);
                    emit_byte(w[7:0]);
                end
                default: emit_byte(w[7:0]);
            endcase
        endfunction

        function void put_terminator();
            case (cfg.target_convention)
                CONV_CR:   put_code(CH_CR);
                CONV_LF:   put_code(CH_LF);
                CONV_CRLF: begin
                    put_code(CH_CR);
                    put_code(CH_LF);
                end
                default: ;
            endcase
        endfunction

        function void handle_code(logic [15:0] w);
            if (halted) return;
            if (w <= CTRL_LOW_MAX || (w >= CTRL_HIGH_MIN && w <= CTRL_HIGH_MAX)) begin
                prev_newline = 1'b0;
                non_text     = 1'b1;
                if (cfg.stop_on_non_text) begin
                    halted = 1'b1;
                    return;
                end
            end
            if (w == CH_CR) begin
                // a CR is only counted once it turns out not to open a CRLF
                if (prev_cr) cr_cnt = bump(cr_cnt);
                put_terminator();
                prev_cr      = 1'b1;
                prev_newline = 1'b1;
            end else if (w == CH_LF) begin
                prev_newline = 1'b1;
                if (prev_cr) begin
                    // terminator already written for the CR
                    prev_cr  = 1'b0;
                    crlf_cnt = bump(crlf_cnt);
                    if (cfg.stop_on_foreign_ending && cfg.target_convention != CONV_CRLF)
                        halted = 1'b1;
                end else begin
                    put_terminator();
                    lf_cnt = bump(lf_cnt);
                    if (cfg.stop_on_foreign_ending && cfg.target_convention != CONV_LF)
                        halted = 1'b1;
                end
            end else begin
                if (prev_cr) cr_cnt = bump(cr_cnt);
                put_code(w);
                prev_cr      = 1'b0;
                prev_newline = 1'b0;
            end
        endfunction

        function logic [15:0] join_pair(logic [7:0] a, logic [7:0] b);
            return (layout == LAYOUT_LE) ? {b, a} : {a, b};
        endfunction

        // Note one accepted input transfer and queue what it must produce.
        function void take_input(t_in it);
            t_out rep;
            batch.delete();
            if (it.func == FUNC_DATA) begin
                if (bytes_seen == 2'd0) begin
                    first_byte = it.in_byte;
                    bytes_seen = 2'd1;
                end else if (bytes_seen == 2'd1) begin
                    bytes_seen = 2'd2;
                    if (first_byte == BOM_FF && it.in_byte == BOM_FE)
                        layout = LAYOUT_LE;
                    else if (first_byte == BOM_FE && it.in_byte == BOM_FF)
                        layout = LAYOUT_BE;
                    else
                        layout = LAYOUT_8;
                    if (layout == LAYOUT_8) begin
                        handle_code({8'h00, first_byte});
                        handle_code({8'h00, it.in_byte});
                    end else begin
                        handle_code(join_pair(first_byte, it.in_byte));
                    end
                end else if (layout != LAYOUT_8) begin
                    if (half_pending) begin
                        half_pending = 1'b0;
                        handle_code(join_pair(half_byte, it.in_byte));
                    end else begin
                        half_byte    = it.in_byte;
                        half_pending = 1'b1;
                    end
                end else begin
                    handle_code({8'h00, it.in_byte});
                end
            end else begin
                if (bytes_seen == 2'd1) handle_code({8'h00, first_byte});
                if (prev_cr) begin
                    cr_cnt  = bump(cr_cnt);
                    prev_cr = 1'b0;
                end
                if (cfg.force_final_ending && !prev_newline) put_terminator();
                if (batch.size() < MAX_RESULTS) begin
                    rep              = '0;
                    rep.kind         = KIND_REPORT;
                    rep.cr_total     = cr_cnt;
                    rep.lf_total     = lf_cnt;
                    rep.crlf_total   = crlf_cnt;
                    rep.saw_non_text = non_text;
                    rep.was_stopped  = halted;
                    batch.push_back(rep);
                end
                clear_stream();
            end
            if (batch.size() > 0) begin
                rep      = batch.pop_back();
                rep.last = 1'b1;
                batch.push_back(rep);
            end
            foreach (batch[k]) due_results.push_back(batch[k]);
        endfunction

        function string show(t_out r);
            return $sformatf("kind=%0d byte=%02h cr=%0d lf=%0d crlf=%0d nt=%0d stop=%0d last=%0d",
                             r.kind, r.out_byte, r.cr_total, r.lf_total, r.crlf_total,
                             r.saw_non_text, r.was_stopped, r.last);
        endfunction

        function void flag_error(string msg);
            n_errors++;
            if (n_errors <= MAX_REPORTED) $display("%s", msg);
        endfunction

        // Compare one accepted result with the oldest one still owed.
        function void check_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                flag_error({"unexpected result: ", show(got)});
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.cr_total !== want.cr_total || got.lf_total !== want.lf_total ||
                got.crlf_total !== want.crlf_total || got.saw_non_text !== want.saw_non_text ||
                got.was_stopped !== want.was_stopped || got.last !== want.last)
                flag_error({"result mismatch\n  expected ", show(want),
                            "\n  actual   ", show(got)});
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lec_stream_if #(.T(t_in))  in_if  ();
    lec_stream_if #(.T(t_out)) out_if ();

    ending_checker conv_check = new();

    int   tx_gap_pct   = 0;     // chance of an idle cycle before each offer
    int   rx_stall_pct = 0;     // chance of ready low in a cycle
    int   hold_left    = 0;     // cycles of forced receiver hold-off still to run
    int   items_done   = 0;     // input transfers accepted so far
    t_cfg phase_plan [N_PHASES];

    line_ending_converter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one transfer, with random idle cycles ahead of it, and hold it
    // until the block takes it. Valid stays high on return so back-to-back
    // transfers never drop it for a cycle.
    task automatic send_item(input t_in item);
        logic [8:0] junk;
        while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            junk          = 9'($urandom_range(511));
            in_if.valid  <= 1'b0;
            in_if.data   <= junk;           // noise on the bus while idle
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        conv_check.take_input(item);
        items_done++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in it;
        it.func    = FUNC_DATA;
        it.in_byte = b;
        send_item(it);
    endtask

    // End of stream; the byte field is don't-care, so randomize it.
    task automatic send_end();
        t_in it;
        it.func    = FUNC_END;
        it.in_byte = 8'($urandom_range(255));
        send_item(it);
    endtask

    task automatic send_code(input logic [1:0] lay, input logic [15:0] w);
        case (lay)
            LAYOUT_LE: begin
                send_byte(w[7:0]);
                send_byte(w[15:8]);
            end
            LAYOUT_BE: begin
                send_byte(w[15:8]);
                send_byte(w[7:0]);
            end
            default: send_byte(w[7:0]);
        endcase
    endtask

    // Mostly printable text and terminators, some control codes and raw
    // bytes; wide code points sometimes get a nonzero high byte.
    function automatic logic [15:0] pick_code(input bit wide);
        int          r;
        logic [15:0] v;
        r = $urandom_range(99);
        if (r < 35)      v = 16'($urandom_range(32, 126));
        else if (r < 47) v = CH_CR;
        else if (r < 59) v = CH_LF;
        else if (r < 67) v = 16'($urandom_range(31));
        else             v = 16'($urandom_range(255));
        if (wide && $urandom_range(4) == 0) v[15:8] = 8'($urandom_range(255));
        return v;
    endfunction

    // Drop valid and hold until every owed result has left the block, then
    // let the given number of quiet cycles pass.
    task automatic wait_for_results(input int settle);
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (conv_check.due_results.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // One stream: optional byte-order mark, random code points, an odd
    // trailing byte now and then, closed by end of stream.
    task automatic send_random_stream(input bit pause_midway);
        int          pick;
        int          len;
        int          k;
        logic [1:0]  lay;
        pick = $urandom_range(9);
        len  = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        if (pause_midway) len = 6;
        if (pick < 3) begin
            lay = LAYOUT_LE;
            send_byte(BOM_FF);
            send_byte(BOM_FE);
        end else if (pick < 6) begin
            lay = LAYOUT_BE;
            send_byte(BOM_FE);
            send_byte(BOM_FF);
        end else if (pick < 9) begin
            lay = LAYOUT_8;
        end else begin
            // broken mark: stays 8-bit
            lay = LAYOUT_8;
            send_byte(BOM_FF);
            send_byte(BOM_FF);
        end
        for (k = 0; k < len; k++) begin
            if (pause_midway && k == len / 2) wait_for_results(0);
            if ($urandom_range(7) == 0) begin
                send_code(lay, CH_CR);
                send_code(lay, CH_LF);
            end else begin
                send_code(lay, pick_code(lay != LAYOUT_8));
            end
        end
        if (lay != LAYOUT_8 && $urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
        send_end();
    endtask

    // Write one register; only called while idle.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        put_reg(CFG_TARGET,       c.target_convention);
        put_reg(CFG_STOP_NT,      {1'b0, c.stop_on_non_text});
        put_reg(CFG_STOP_FOREIGN, {1'b0, c.stop_on_foreign_ending});
        put_reg(CFG_FORCE_FINAL,  {1'b0, c.force_final_ending});
        put_reg(CFG_OUT_EN,       {1'b0, c.output_enable});
        i_cfg_we     <= 1'b0;
        conv_check.cfg = c;
    endtask

    // Drain, switch the stall pattern away from the clock edge, then write
    // the new setting.
    task automatic start_phase(input t_cfg c, input int mode);
        wait_for_results(SETTLE_CYCLES);
        @(negedge i_clk);
        case (mode)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 45; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 45; end
            default: begin tx_gap_pct = 19; rx_stall_pct = 19; end
        endcase
        @(posedge i_clk);
        apply_config(c);
    endtask

    // Receiver: check each accepted result, then pick ready for the next
    // cycle. A requested hold-off keeps ready low and is counted down here.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
                conv_check.check_result(out_if.data);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int quota;
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_TARGET;
        i_cfg_data  = '0;

        // extremes first: terminators, stops, final ending, check-only,
        // then two random settings and finally the reset setting
        phase_plan[0] = '{CONV_CRLF, 1'b0, 1'b0, 1'b1, 1'b1};
        phase_plan[1] = '{CONV_NONE, 1'b0, 1'b0, 1'b1, 1'b1};
        phase_plan[2] = '{CONV_CR,   1'b1, 1'b1, 1'b1, 1'b1};
        phase_plan[3] = '{CONV_LF,   1'b0, 1'b1, 1'b0, 1'b1};
        phase_plan[4] = '{CONV_CRLF, 1'b1, 1'b1, 1'b0, 1'b0};
        phase_plan[5] = 6'($urandom_range(63));
        phase_plan[6] = 6'($urandom_range(63));
        phase_plan[7] = '{CONV_LF,   1'b0, 1'b0, 1'b0, 1'b1};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed streams under the reset setting.
        send_end();                                 // empty stream
        send_byte(8'h41);                           // one-byte stream
        send_end();
        // 16-bit little-endian: CRLF, a CR left open at the end, odd trailing byte
        send_byte(BOM_FF);
        send_byte(BOM_FE);
        send_byte(8'h0D);
        send_byte(8'h00);
        send_byte(8'h0A);
        send_byte(8'h00);
        send_byte(8'h0D);
        send_byte(8'h00);
        send_byte(8'h41);
        send_end();
        // 16-bit big-endian lone LF
        send_byte(BOM_FE);
        send_byte(BOM_FF);
        send_byte(8'h00);
        send_byte(8'h0A);
        send_end();
        // 8-bit: byte extremes, CR CR LF, a control code
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0D);
        send_byte(8'h0D);
        send_byte(8'h0A);
        send_byte(8'h0E);
        send_end();

        for (int p = 0; p < N_PHASES; p++) begin
            start_phase(phase_plan[p], p % 4);
            if (p == 0) begin
                // long receiver hold-off while the sender keeps offering,
                // so the job queue fills and input backs up
                @(negedge i_clk);
                hold_left = LONG_HOLD;
                @(posedge i_clk);
            end
            send_end();                             // empty stream under this setting
            quota = items_done + ITEMS_PER_PHASE;
            send_random_stream(p == 2);             // phase 2: sender pauses mid-stream
            while (items_done < quota) send_random_stream(1'b0);
        end

        wait_for_results(SETTLE_CYCLES);
        if (conv_check.n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
